/* hdl/rlab_pkg.sv */
// Package: fixed-point constants, matrix coefficients and sRGB linearising function.
`timescale 1ns / 1ps
package rlab_pkg;

  localparam int QB = 30;
  localparam logic [63:0] QONE  = 64'd1 << QB;
  localparam logic [63:0] QHALF = 64'd1 << (QB - 1);

  // Register count of the cube-root unit: one per root bit plus the final select
  localparam int ROOT_LAT = QB + 2;

  typedef logic [30:0] q31_t;
  typedef logic [32:0] lin_num_t;

  // ceil(2^37 / 125): exact floor division by 125 for arguments below 2^30
  localparam logic [30:0] RECIP_125 = 31'd1099511628;

  // sRGB-to-XYZ rows, each pre-divided by its white point, Q30
  localparam logic [29:0] MAT [3][3] = '{
    '{30'(((64'd4124 * 64'd10) << QB) / 64'd95047),
      30'(((64'd3576 * 64'd10) << QB) / 64'd95047),
      30'(((64'd1805 * 64'd10) << QB) / 64'd95047)},
    '{30'((64'd2126 << QB) / 64'd10000),
      30'((64'd7152 << QB) / 64'd10000),
      30'((64'd722 << QB) / 64'd10000)},
    '{30'(((64'd193 * 64'd10) << QB) / 64'd108883),
      30'(((64'd1192 * 64'd10) << QB) / 64'd108883),
      30'(((64'd9505 * 64'd10) << QB) / 64'd108883)}
  };

  localparam logic [30:0] LAB_THR = 31'((64'd8856 << QB) / 64'd1000000);
  localparam logic [30:0] LAB_OFS = 31'(((64'd16 << QB) + 64'd58) / 64'd116);

  function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
    return (a * b + QHALF) >> QB;
  endfunction

  // fifth root by bit search, argument in Q30 no greater than one
  function automatic logic [63:0] root5(input logic [63:0] w);
    logic [63:0] r;
    logic [63:0] c;
    logic [63:0] p;
    r = 64'd0;
    if (w >= QONE) begin
      return QONE;
    end
    for (int b = QB - 1; b >= 0; b--) begin
      c = r | (64'd1 << b);
      p = qmul(qmul(c, c), c);
      p = qmul(qmul(p, c), c);
      if (p <= w) begin
        r = c;
      end
    end
    return r;
  endfunction

  // sRGB code to linear light in Q30
  function automatic logic [30:0] srgb_lin(input int code);
    logic [63:0] c;
    logic [63:0] v;
    logic [63:0] w;
    c = 64'(code);
    if (c * 64'd100000 <= 64'd1031475) begin
      return 31'((((c * 64'd100) << QB) + 64'd164730) / 64'd329460);
    end
    v = (((c * 64'd1000 + 64'd14025) << QB) + 64'd134512) / 64'd269025;
    w = qmul(v, v);
    return 31'(qmul(w, root5(w)));
  endfunction

endpackage

/* hdl/rlab_if.sv */
// Interfaces: pixel input channel and CIELAB result channel.
`timescale 1ns / 1ps
interface rlab_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source(output valid, output red, output green, output blue, input ready);
  modport sink(input valid, input red, input green, input blue, output ready);
endinterface

interface rlab_out_if;
  logic               valid;
  logic               ready;
  logic [14:0]        lightness;
  logic signed [15:0] green_red;
  logic signed [15:0] blue_yellow;
  modport source(output valid, output lightness, output green_red, output blue_yellow,
                 input ready);
  modport sink(input valid, input lightness, input green_red, input blue_yellow,
               output ready);
endinterface

/* hdl/rgb_to_cielab.sv */
// Top level: sRGB pixel to CIELAB (D65) converter, one pixel per clock unless stalled.
//
//  port    dir  contents
//  pixel   in   red, green, blue (8-bit sRGB codes)
//  lab     out  lightness (u15), green_red (s16), blue_yellow (s16), FRAC_BITS fraction bits
//
// One pixel enters per clock unless the pipeline holds; the cube root is 31 stages deep.
// Reset (rst, synchronous) clears the stage valid bits only.
// When a result waits on lab.ready the whole pipeline holds; nothing is dropped.
`timescale 1ns / 1ps
module rgb_to_cielab #(
  parameter int FRAC_BITS = 8
) (
  input logic       clk,
  input logic       rst,
  rlab_in_if.sink   pixel,
  rlab_out_if.source lab
);
  import rlab_pkg::*;

  localparam int SH   = QB - FRAC_BITS;
  localparam int LMAX = ((100 << FRAC_BITS) > 32767) ? 32767 : (100 << FRAC_BITS);
  localparam int NST  = 4 + ROOT_LAT + 2;

  logic        v [NST];
  logic        en;
  logic [30:0] lin_rom [256];
  logic [30:0] lin  [3];
  logic [60:0] prod [3][3];
  logic [30:0] t    [3];
  logic [30:0] t4   [3];
  logic        rsel4 [3];
  logic [32:0] num4 [3];
  logic [30:0] f    [3];
  logic signed [41:0] lv, av, bv;
  logic [14:0]        lightness;
  logic signed [15:0] green_red, blue_yellow;

  for (genvar g = 0; g < 256; g++) begin : g_rom
    localparam logic [30:0] LV = srgb_lin(g);
    assign lin_rom[g] = LV;
  end

  assign en          = !(v[NST-1] && !lab.ready);
  assign pixel.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NST; i++) begin
        v[i] <= 1'b0;
      end
    end else if (en) begin
      v[0] <= pixel.valid;
      for (int i = 1; i < NST; i++) begin
        v[i] <= v[i-1];
      end
    end
  end

  // linearise, matrix products, row sums, linear-segment numerator
  always_ff @(posedge clk) begin
    if (en) begin
      lin[0] <= lin_rom[pixel.red];
      lin[1] <= lin_rom[pixel.green];
      lin[2] <= lin_rom[pixel.blue];
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod[i][j] <= 61'(MAT[i][j]) * 61'(lin[j]);
        end
        t[i]    <= 31'((63'(prod[i][0]) + 63'(prod[i][1]) + 63'(prod[i][2])
                        + 63'(QHALF)) >> QB);
        t4[i]   <= t[i];
        rsel4[i] <= t[i] > LAB_THR;
        num4[i] <= (t[i] > LAB_THR) ? '0
                   : 33'(t[i][23:0]) * 33'd787 + 33'd500;
      end
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_ch
    rlab_froot u_froot (
      .clk     (clk),
      .en      (en),
      .t_in    (t4[c]),
      .root_in (rsel4[c]),
      .num_in  (num4[c]),
      .f       (f[c])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lv <= signed'(42'(f[1])) * 42'sd116 - (42'sd16 <<< QB);
      av <= 42'sd500 * (signed'(42'(f[0])) - signed'(42'(f[1])));
      bv <= 42'sd200 * (signed'(42'(f[1])) - signed'(42'(f[2])));
    end
  end

  // round half up to FRAC_BITS and saturate
  always_comb begin
    logic signed [41:0] lr, ar, br;
    lr = (lv + (42'sd1 <<< (SH - 1))) >>> SH;
    ar = (av + (42'sd1 <<< (SH - 1))) >>> SH;
    br = (bv + (42'sd1 <<< (SH - 1))) >>> SH;
    if (lr < 42'sd0) begin
      lightness = '0;
    end else if (lr > 42'(LMAX)) begin
      lightness = 15'(LMAX);
    end else begin
      lightness = lr[14:0];
    end
    if (ar < -42'sd32768) begin
      green_red = -16'sd32768;
    end else if (ar > 42'sd32767) begin
      green_red = 16'sd32767;
    end else begin
      green_red = ar[15:0];
    end
    if (br < -42'sd32768) begin
      blue_yellow = -16'sd32768;
    end else if (br > 42'sd32767) begin
      blue_yellow = 16'sd32767;
    end else begin
      blue_yellow = br[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lab.lightness   <= lightness;
      lab.green_red   <= green_red;
      lab.blue_yellow <= blue_yellow;
    end
  end

  assign lab.valid = v[NST-1];

endmodule

/* hdl/rlab_froot.sv */
// CIELAB f(t): pipelined bitwise cube root beside a reciprocal-multiply divide for the linear segment.
`timescale 1ns / 1ps
module rlab_froot (
  input  logic              clk,
  input  logic              en,
  input  rlab_pkg::q31_t    t_in,
  input  logic              root_in,
  input  rlab_pkg::lin_num_t num_in,
  output rlab_pkg::q31_t    f
);
  import rlab_pkg::*;

  localparam int NB = QB + 1;

  logic [30:0] rr   [NB+1];
  logic [61:0] rsq  [NB+1];
  logic [30:0] tt   [NB+1];
  logic        sel  [NB+1];
  logic [60:0] mq;
  logic [23:0] dq   [NB-1];

  assign rr[0]  = '0;
  assign rsq[0] = '0;
  assign tt[0]  = t_in;
  assign sel[0] = root_in;

  for (genvar g = 0; g < NB; g++) begin : g_bit
    localparam int K = NB - 1 - g;
    logic [30:0] cand;
    logic [61:0] csq;
    logic [31:0] sq_r;
    logic [62:0] cube;
    logic [32:0] cube_r;

    always_comb begin
      cand   = rr[g] | (31'd1 << K);
      csq    = rsq[g] + (62'(rr[g]) << (K + 1)) + (62'd1 << (2 * K));
      sq_r   = 32'((64'(csq) + QHALF) >> QB);
      cube   = 63'(sq_r) * 63'(cand);
      cube_r = 33'((64'(cube) + QHALF) >> QB);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (cube_r <= 33'(tt[g])) begin
          rr[g+1]  <= cand;
          rsq[g+1] <= csq;
        end else begin
          rr[g+1]  <= rr[g];
          rsq[g+1] <= rsq[g];
        end
        tt[g+1]  <= tt[g];
        sel[g+1] <= sel[g];
      end
    end
  end

  // linear segment: 7t plus (787t + 500) / 1000 plus 16/116, taken as (num / 8) / 125
  always_ff @(posedge clk) begin
    if (en) begin
      mq    <= 61'(num_in[32:3]) * 61'(RECIP_125);
      dq[0] <= mq[60:37];
      for (int i = 1; i < NB - 1; i++) begin
        dq[i] <= dq[i-1];
      end
      f <= sel[NB] ? rr[NB] : 31'(dq[NB-2]) + tt[NB] * 31'd7 + LAB_OFS;
    end
  end

endmodule

/* dv/rlab_checker.sv */
// Checker: watches both channels, predicts CIELAB results and compares them.
`timescale 1ns / 1ps
module rlab_checker #(
  parameter int FRAC_BITS = 8
) (
  input  logic clk,
  input  logic rst,
  rlab_in_if.sink  pixel_mon,
  rlab_out_if.sink lab_mon,
  output int       fail_count,
  output int       pending
);

  localparam int QBITS = 30;
  localparam logic [63:0] ONE_Q  = 64'd1 << QBITS;
  localparam logic [63:0] HALF_Q = 64'd1 << (QBITS - 1);
  localparam int SHIFT = QBITS - FRAC_BITS;
  localparam longint OFFSET = longint'(1) << 45;

  typedef struct packed {
    logic [14:0]        lightness;
    logic signed [15:0] green_red;
    logic signed [15:0] blue_yellow;
  } lab_t;

  lab_t lab_q[$];
  logic [63:0] coef [3][3];
  logic [63:0] lin_rom [256];

  function automatic logic [63:0] mul_q(input logic [63:0] a, input logic [63:0] b);
    return (a * b + HALF_Q) >> QBITS;
  endfunction

  function automatic logic [63:0] fifth_root(input logic [63:0] w);
    logic [63:0] r;
    logic [63:0] c;
    logic [63:0] p;
    r = 0;
    if (w >= ONE_Q) return ONE_Q;
    for (int k = QBITS - 1; k >= 0; k--) begin
      c = r | (64'd1 << k);
      p = mul_q(mul_q(mul_q(mul_q(c, c), c), c), c);
      if (p <= w) r = c;
    end
    return r;
  endfunction

  function automatic logic [63:0] cube_root(input logic [63:0] t);
    logic [63:0] r;
    logic [63:0] c;
    r = 0;
    for (int k = QBITS; k >= 0; k--) begin
      c = r | (64'd1 << k);
      if (mul_q(mul_q(c, c), c) <= t) r = c;
    end
    return r;
  endfunction

  function automatic logic [63:0] linearise(input logic [63:0] c);
    logic [63:0] v;
    logic [63:0] w;
    if (c * 100000 <= 1031475) return (((c * 100) << QBITS) + 164730) / 329460;
    v = (((c * 1000 + 14025) << QBITS) + 134512) / 269025;
    w = mul_q(v, v);
    return mul_q(w, fifth_root(w));
  endfunction

  function automatic logic [63:0] lab_curve(input logic [63:0] t);
    logic [63:0] thr;
    thr = (64'd8856 << QBITS) / 1000000;
    if (t > thr) return cube_root(t);
    return (t * 7787 + 500) / 1000 + (((64'd16 << QBITS) + 58) / 116);
  endfunction

  function automatic longint to_frac(input longint v);
    logic [63:0] u;
    u = (64'(v + OFFSET) + (64'd1 << (SHIFT - 1))) >> SHIFT;
    return longint'(u) - (OFFSET >>> SHIFT);
  endfunction

  function automatic longint sat(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic lab_t convert(input logic [7:0] r, input logic [7:0] g,
                                   input logic [7:0] b);
    logic [63:0] lin [3];
    logic [63:0] f [3];
    logic [63:0] acc;
    longint lv, av, bv, lmax;
    lab_t res;
    lin[0] = lin_rom[r];
    lin[1] = lin_rom[g];
    lin[2] = lin_rom[b];
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += coef[i][j] * lin[j];
      f[i] = lab_curve((acc + HALF_Q) >> QBITS);
    end
    lv = to_frac(longint'(116 * f[1]) - (longint'(16) << QBITS));
    av = to_frac(500 * (longint'(f[0]) - longint'(f[1])));
    bv = to_frac(200 * (longint'(f[1]) - longint'(f[2])));
    lmax = longint'(100) << FRAC_BITS;
    if (lmax > 32767) lmax = 32767;
    res.lightness   = 15'(sat(lv, 0, lmax));
    res.green_red   = 16'(sat(av, -32768, 32767));
    res.blue_yellow = 16'(sat(bv, -32768, 32767));
    return res;
  endfunction

  initial begin
    coef[0][0] = ((64'd41240) << QBITS) / 95047;
    coef[0][1] = ((64'd35760) << QBITS) / 95047;
    coef[0][2] = ((64'd18050) << QBITS) / 95047;
    coef[1][0] = (64'd2126 << QBITS) / 10000;
    coef[1][1] = (64'd7152 << QBITS) / 10000;
    coef[1][2] = (64'd722 << QBITS) / 10000;
    coef[2][0] = ((64'd1930) << QBITS) / 108883;
    coef[2][1] = ((64'd11920) << QBITS) / 108883;
    coef[2][2] = ((64'd95050) << QBITS) / 108883;
    for (int c = 0; c < 256; c++) lin_rom[c] = linearise(64'(c));
  end

  always @(posedge clk) begin
    lab_t got, want;
    int errs;
    errs = 0;
    if (rst) begin
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (pixel_mon.valid && pixel_mon.ready)
        lab_q.insert(lab_q.size(),
                     convert(pixel_mon.red, pixel_mon.green, pixel_mon.blue));
      if (lab_mon.valid && lab_mon.ready) begin
        got = '{lab_mon.lightness, lab_mon.green_red, lab_mon.blue_yellow};
        if (lab_q.size() == 0) begin
          $error("unexpected result L=%0d a=%0d b=%0d", got.lightness, got.green_red,
                 got.blue_yellow);
          errs++;
        end else begin
          want = lab_q.pop_front();
          if (got.lightness !== want.lightness) begin
            $error("lightness: expected %0d, got %0d", want.lightness, got.lightness);
            errs++;
          end
          if (got.green_red !== want.green_red) begin
            $error("green_red: expected %0d, got %0d", want.green_red, got.green_red);
            errs++;
          end
          if (got.blue_yellow !== want.blue_yellow) begin
            $error("blue_yellow: expected %0d, got %0d", want.blue_yellow,
                   got.blue_yellow);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
      pending    <= lab_q.size();
    end
  end

endmodule

/* dv/tb.sv */
// Testbench top: drives pixels, stalls the result side and gives the verdict.
`timescale 1ns / 1ps
module tb;

  localparam int FRAC_BITS = 8;
  localparam int N_RANDOM = 1150;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  logic [23:0] pixels[$];

  rlab_in_if  pixel ();
  rlab_out_if lab ();

  rgb_to_cielab #(.FRAC_BITS(FRAC_BITS)) DUT (
    .clk(clk), .rst(rst), .pixel(pixel), .lab(lab)
  );

  rlab_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (
    .clk(clk), .rst(rst), .pixel_mon(pixel), .lab_mon(lab),
    .fail_count(fail_count), .pending(pending)
  );

  function automatic void add_pixel(input logic [23:0] p);
    pixels.insert(pixels.size(), p);
  endfunction

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

  // Result side: draw a stall per item, with stall-free stretches
  initial begin
    int gap;
    lab.ready = 0;
    @(posedge clk iff !rst);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      repeat (gap) begin
        lab.ready <= 0;
        @(posedge clk);
      end
      lab.ready <= 1;
      @(posedge clk iff lab.valid);
    end
  end

  initial begin
    int gap;
    int burst;
    logic [7:0] ex [4] = '{8'd0, 8'd255, 8'd10, 8'd11};
    rst = 1;
    pixel.valid = 0;
    pixel.red = 0;
    pixel.green = 0;
    pixel.blue = 0;
    // extremes and the knee of the sRGB curve
    for (int i = 0; i < 4; i++) add_pixel({ex[i], ex[i], ex[i]});
    add_pixel({8'd255, 8'd0, 8'd0});
    add_pixel({8'd0, 8'd255, 8'd0});
    add_pixel({8'd0, 8'd0, 8'd255});
    add_pixel({8'd255, 8'd255, 8'd0});
    add_pixel({8'd255, 8'd0, 8'd255});
    add_pixel({8'd0, 8'd255, 8'd255});
    add_pixel({8'd1, 8'd1, 8'd1});
    add_pixel({8'd254, 8'd254, 8'd254});
    add_pixel({8'd255, 8'd0, 8'd1});
    add_pixel({8'd0, 8'd1, 8'd255});
    add_pixel({8'd3, 8'd0, 8'd0});
    add_pixel({8'd0, 8'd0, 8'd3});
    add_pixel({8'h55, 8'hAA, 8'h55});
    add_pixel({8'hAA, 8'h55, 8'hAA});
    for (int i = 0; i < N_RANDOM; i++) add_pixel(24'($urandom));
    repeat (11) @(posedge clk);
    rst <= 0;
    burst = 0;
    while (pixels.size() > 0) begin
      if (burst > 0) begin
        burst--;
        gap = 0;
      end else if ($urandom_range(0, 15) == 0) begin
        burst = $urandom_range(20, 60);
        gap = 0;
      end else begin
        gap = $urandom_range(0, 12);
      end
      repeat (gap) begin
        pixel.valid <= 0;
        @(posedge clk);
      end
      {pixel.red, pixel.green, pixel.blue} <= pixels.pop_front();
      pixel.valid <= 1;
      @(posedge clk iff pixel.ready);
    end
    pixel.valid <= 0;
    while (pending > 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/rlab_pkg.sv
hdl/rlab_if.sv
hdl/rlab_froot.sv
hdl/rgb_to_cielab.sv
dv/rlab_checker.sv
dv/tb.sv
